// ===== rtl/sitda_pkg.sv =====
// shared types for the signed integer to decimal ascii block
// state encoding, controller commands, datapath status and character codes
package sitda_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned NumDigits  = 10;
    localparam int unsigned BcdWidth   = 4 * NumDigits;
    localparam int unsigned CodeWidth  = 7;
    localparam int unsigned IdxWidth   = 4;
    localparam int unsigned StepWidth  = 3;

    localparam logic [CodeWidth-1:0] CODE_ZERO  = 7'd48;
    localparam logic [CodeWidth-1:0] CODE_MINUS = 7'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_SIGN,
        S_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic scan;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic last_shift;
        logic negative;
        logic out_free;
        logic last_digit;
    } stat_t;

endpackage

// ===== rtl/sitda_in_if.sv =====
// input channel of the signed integer to decimal ascii block
// depends on sitda_pkg for the value width
interface sitda_in_if
    import sitda_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [ValueWidth-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/sitda_out_if.sv =====
// output channel of the signed integer to decimal ascii block
// depends on sitda_pkg for the character code width
interface sitda_out_if
    import sitda_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CodeWidth-1:0] char_code;
    logic                 last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== rtl/sitda_datapath.sv =====
// datapath: magnitude, shift-add-3 bcd conversion, digit index and output register
// depends on sitda_pkg for command and status types
module sitda_datapath
    import sitda_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output stat_t                        stat,
    input  logic signed [ValueWidth-1:0] value,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [CodeWidth-1:0]         char_code,
    output logic                         last
);

    logic [ValueWidth-1:0] mag_reg,      mag_next;
    logic [BcdWidth-1:0]   bcd_reg,      bcd_next;
    logic [StepWidth-1:0]  step_reg,     step_next;
    logic                  neg_reg,      neg_next;
    logic [IdxWidth-1:0]   idx_reg,      idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CodeWidth-1:0]  char_reg,     char_next;
    logic                  last_reg,     last_next;

    logic [ValueWidth-1:0] mag_shift;
    logic [BcdWidth-1:0]   bcd_shift;
    logic [IdxWidth-1:0]   top_idx;
    logic [3:0]            cur_digit;

    function automatic logic [BcdWidth-1:0] add3(input logic [BcdWidth-1:0] b);
        logic [BcdWidth-1:0] r;
        r = b;
        for (int i = 0; i < NumDigits; i++)
        begin
            if (r[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = r[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // four conversion bits per cycle
    always_comb
    begin
        logic [BcdWidth-1:0]   b;
        logic [ValueWidth-1:0] m;
        b = bcd_reg;
        m = mag_reg;
        for (int s = 0; s < 4; s++)
        begin
            b = add3(b);
            b = {b[BcdWidth-2:0], m[ValueWidth-1]};
            m = {m[ValueWidth-2:0], 1'b0};
        end
        bcd_shift = b;
        mag_shift = m;
    end

    // highest nonzero digit, zero gives digit 0
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NumDigits; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                top_idx = IdxWidth'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: 4];

    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            neg_next  = value[ValueWidth-1];
            mag_next  = value[ValueWidth-1] ? (~value + 1'b1) : value;
            bcd_next  = '0;
            step_next = '0;
        end
        if (cmd.shift)
        begin
            mag_next  = mag_shift;
            bcd_next  = bcd_shift;
            step_next = step_reg + 1'b1;
        end
        if (cmd.scan)
        begin
            idx_next = top_idx;
        end
        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            char_next      = CODE_MINUS;
            last_next      = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            char_next      = CODE_ZERO + {3'b000, cur_digit};
            last_next      = (idx_reg == '0);
            idx_next       = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign stat.last_shift = (step_reg == '1);
    assign stat.negative   = neg_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.last_digit = (idx_reg == '0);

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/sitda_ctrl.sv =====
// controller state machine: load, convert, scan, emit sign and digits
// depends on sitda_pkg for state, command and status types
module sitda_ctrl
    import sitda_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (stat.last_shift)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = stat.negative ? S_SIGN : S_DIGIT;
            end
            S_SIGN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (stat.out_free && stat.last_digit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_CONV:
            begin
                cmd.shift = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_SIGN:
            begin
                cmd.emit_sign = stat.out_free;
            end
            S_DIGIT:
            begin
                cmd.emit_digit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// signed 32-bit integer to decimal ascii text, top level
// uses sitda_pkg, sitda_in_if, sitda_out_if, sitda_ctrl and sitda_datapath
//
// in_ch carries one signed 32-bit value per item. out_ch carries one ascii
// character per item, most significant first, '-' ahead of negative values,
// no leading zeros, last set on the final character. zero gives "0".
// an accepted value is loaded, converted by shift-add-3 at four bits per
// cycle and scanned for the top digit; then each character (1 to 11 in all)
// is sent as the output register frees. a new value is taken once the final
// character sits in the output register; no new value is taken while an
// item is being converted or emitted through the single output register.
// a stalled receiver holds the output register and the emit sequence waits;
// nothing is dropped. reset clears the controller and the output valid flag.
module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    sitda_in_if.sink    in_ch,
    sitda_out_if.source out_ch
);

    cmd_t  cmd;
    stat_t stat;

    sitda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sitda_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (in_ch.value),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .char_code (out_ch.char_code),
        .last      (out_ch.last)
    );

endmodule

// ===== dv/tb_top.sv =====
// testbench for signed_int_to_decimal_ascii_top: drives signed values, predicts the decimal text
// and checks each character item; depends on sitda_pkg, sitda_in_if and sitda_out_if from rtl
module tb_top
    import sitda_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumDirected = 20;
    localparam int NumRandom   = 300;
    localparam int HoldCycles  = 400;

    typedef struct {
        logic [CodeWidth-1:0] code;
        logic                 last;
    } text_char_t;

    logic clk;
    logic rst_n;

    sitda_in_if  in_if ();
    sitda_out_if out_if ();

    signed_int_to_decimal_ascii_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    text_char_t pending_chars[$];
    int         err_cnt       = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_cnt      = 0;

    // directed rows: an empty text means the predictor supplies the characters
    logic signed [ValueWidth-1:0] dir_values[NumDirected] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
        32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
        -32'sd1000000000, 32'sd999999999, -32'sd999999999, 32'sd123456789,
        32'h5555_5555, 32'hAAAA_AAAA, 32'sd1000000001, 32'hFFFF_FFFE
    };
    string dir_texts[NumDirected] = '{
        "0", "1", "-1", "9", "10", "-10", "99", "100",
        "2147483647", "-2147483648", "-2147483647", "1000000000",
        "-1000000000", "", "", "",
        "", "", "", "-2"
    };

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic void push_decimal_chars(input logic [ValueWidth-1:0] v);
        logic                 negative;
        logic [ValueWidth-1:0] mag;
        logic [3:0]           digits[NumDigits];
        int                   ndig;
        text_char_t           c;
        negative = v[ValueWidth-1];
        mag      = negative ? (~v + 1'b1) : v;
        ndig     = 0;
        do
        begin
            digits[ndig] = 4'(mag % 10);
            mag          = mag / 10;
            ndig++;
        end
        while (mag != 0 && ndig < NumDigits);
        if (negative)
        begin
            c.code = CODE_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            c.code = CODE_ZERO + CodeWidth'(digits[k]);
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic void push_text_chars(input string txt);
        text_char_t c;
        for (int i = 0; i < txt.len(); i++)
        begin
            c.code = CodeWidth'(txt[i]);
            c.last = (i == txt.len() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    // called at a falling edge, returns at the falling edge after the accept
    task automatic offer_value(input logic signed [ValueWidth-1:0] v, input string txt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do
            @(posedge clk);
        while (!in_if.ready);
        if (txt.len() != 0)
            push_text_chars(txt);
        else
            push_decimal_chars(v);
        @(negedge clk);
    endtask

    function automatic logic signed [ValueWidth-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     nd;
        bit     neg;
        if ($urandom_range(3) == 0)
            return $urandom;
        nd  = $urandom_range(1, 10);
        neg = 1'($urandom_range(1));
        lo  = (nd == 1) ? 0 : 10 ** (nd - 1);
        hi  = 10 ** nd - 1;
        if (hi > 64'sd2147483647)
            hi = neg ? 64'sd2147483648 : 64'sd2147483647;
        mag = lo + (longint'($urandom) % (hi - lo + 1));
        return ValueWidth'(neg ? -mag : mag);
    endfunction

    task automatic set_phase(input int idx);
        if (idx < 110)
        begin
            send_idle_pct = 35;
            recv_idle_pct = 77;
        end
        else if (idx < 220)
        begin
            send_idle_pct = 77;
            recv_idle_pct = 35;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // receiver, with a long hold-off when hold_cnt is loaded
    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cnt > 0)
            begin
                out_if.ready <= 1'b0;
                hold_cnt--;
            end
            else
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected item char_code=%0d last=%0b",
                                          out_if.char_code, out_if.last));
            else
            begin
                want = pending_chars.pop_front();
                if (out_if.char_code !== want.code)
                    report_mismatch($sformatf("char_code %0d, wanted %0d",
                                              out_if.char_code, want.code));
                if (out_if.last !== want.last)
                    report_mismatch($sformatf("last %0b, wanted %0b",
                                              out_if.last, want.last));
            end
        end
    end

    initial
    begin
        int idx;
        in_if.valid = 1'b0;
        in_if.value = '0;
        rst_n       = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idx = 0;
        for (int i = 0; i < NumDirected; i++)
        begin
            set_phase(idx);
            offer_value(dir_values[i], dir_texts[i]);
            idx++;
        end
        for (int i = 0; i < NumRandom; i++)
        begin
            set_phase(idx);
            if (idx == 60)
                hold_cnt = HoldCycles;
            if (idx == 160)
            begin
                in_if.valid <= 1'b0;
                while (pending_chars.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            offer_value(random_value(), "");
            idx++;
        end
        in_if.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
        if (err_cnt == 0 && pending_chars.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sitda_pkg.sv
rtl/sitda_in_if.sv
rtl/sitda_out_if.sv
rtl/sitda_datapath.sv
rtl/sitda_ctrl.sv
rtl/signed_int_to_decimal_ascii_top.sv
dv/tb_top.sv
